FILE: rtl/prim_mst_pkg.sv
`default_nettype none

package prim_mst_pkg;

    localparam int unsigned VIDX_W   = 4;
    localparam int unsigned WIN_W    = 16;
    localparam int unsigned TOTAL_W  = 20;
    localparam int unsigned CFG_W    = 5;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 5'd16;

    typedef struct packed {
        logic [VIDX_W-1:0] row;
        logic [VIDX_W-1:0] col;
        logic [WIN_W-1:0]  weight;
        logic              absent;
        logic              last;
    } item_t;

    typedef struct packed {
        logic [VIDX_W-1:0]  vertex;
        logic [VIDX_W-1:0]  parent;
        logic [WIN_W-1:0]   edge_weight;
        logic               reachable;
        logic [TOTAL_W-1:0] total_weight;
        logic               final_res;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/prim_mst_adj_mem.sv
`default_nettype none

module prim_mst_adj_mem #(
    parameter int unsigned DEPTH  = 256,
    parameter int unsigned DATA_W = 17,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/prim_mst_vtx_mem.sv
`default_nettype none

module prim_mst_vtx_mem #(
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned KEY_W  = 16,
    localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [KEY_W-1:0]  wkey,
    input  wire logic [ADDR_W-1:0] wparent,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [KEY_W-1:0]  rkey,
    output logic      [ADDR_W-1:0] rparent
);

    logic [KEY_W-1:0]  key_mem    [DEPTH];
    logic [ADDR_W-1:0] parent_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[waddr]    <= wkey;
            parent_mem[waddr] <= wparent;
        end
        rkey    <= key_mem[raddr];
        rparent <= parent_mem[raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/prim_minimum_spanning_tree.sv
`default_nettype none

// Minimum spanning tree engine over a stored adjacency matrix.
// An item is taken on a rising edge where start is high and busy is low.
// Each item writes one matrix entry. An item with last
// set also grows the tree from vertex 0, and busy stays high meanwhile.
// The vertex count register is written over cfg_valid and cfg_ready.
// Growth scans one vertex per cycle through one shared comparator and the
// single adjacency read port: each pass first selects a vertex and then
// updates keys, and one more selection pass finds no vertex left before
// the results are sent out. A connected graph of n vertices takes n such
// passes, each a selection and an update; a disconnected graph needs fewer.
// Results appear one per cycle in ascending vertex order, each for a
// single cycle under result_valid; the receiver cannot stall them.
// The last result is shown in the final cycle before busy falls.
// Reset clears the control state and sets the vertex count to 16. The
// adjacency memory is not cleared; every entry used must be written first.
module prim_minimum_spanning_tree #(
    parameter int unsigned MAX_VERTICES = 16,
    parameter int unsigned WEIGHT_BITS  = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire prim_mst_pkg::item_t               item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [prim_mst_pkg::CFG_W-1:0]    cfg_data,
    output logic                                   result_valid,
    output prim_mst_pkg::result_t                  result
);

    localparam int unsigned VW = $clog2(MAX_VERTICES);
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned AW = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int unsigned WB = WEIGHT_BITS;
    localparam int unsigned TW = prim_mst_pkg::TOTAL_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SEL  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [prim_mst_pkg::CFG_W-1:0] vcount_reg;
    logic [MAX_VERTICES-1:0]      in_tree_reg, in_tree_next;
    logic [MAX_VERTICES-1:0]      key_valid_reg, key_valid_next;
    logic [CW-1:0]                idx_reg, idx_next;
    logic                         pend_reg, pend_next;
    logic [VW-1:0]                pv_reg, pv_next;
    logic                         found_reg, found_next;
    logic [WB-1:0]                best_reg, best_next;
    logic [VW-1:0]                u_reg, u_next;
    logic [TW-1:0]                total_reg, total_next;
    logic                         res_valid_reg, res_valid_next;
    prim_mst_pkg::result_t        res_reg, res_next;

    logic [CW-1:0]                n_act;
    logic                         accept;
    logic                         adj_we;
    logic [AW-1:0]                adj_waddr;
    logic [AW-1:0]                adj_raddr;
    logic [WB:0]                  adj_rdata;
    logic                         vtx_we;
    logic [VW-1:0]                vtx_waddr;
    logic [WB-1:0]                vtx_wkey;
    logic [VW-1:0]                vtx_wparent;
    logic [WB-1:0]                key_rd;
    logic [VW-1:0]                parent_rd;
    logic [WB-1:0]                cmp_a;
    logic [WB-1:0]                cmp_b;
    logic                         cmp_lt;
    logic [WB-1:0]                adj_w;
    logic                         adj_skip;
    logic                         sel_cand;
    logic                         scan_done;
    logic [WB-1:0]                out_ew;
    logic [VW-1:0]                out_par;

    assign busy         = (state_reg != S_IDLE);
    assign cfg_ready    = (state_reg == S_IDLE);
    assign accept       = start && !busy;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_act = CW'(1);
        end
        else if (32'(vcount_reg) > MAX_VERTICES)
        begin
            n_act = CW'(MAX_VERTICES);
        end
        else
        begin
            n_act = CW'(vcount_reg);
        end
    end

    assign adj_we    = accept && (32'(item.row) < MAX_VERTICES)
                       && (32'(item.col) < MAX_VERTICES);
    assign adj_waddr = AW'(32'(item.row) * MAX_VERTICES + 32'(item.col));
    assign adj_raddr = AW'(32'(u_reg) * MAX_VERTICES + 32'(idx_reg[VW-1:0]));

    prim_mst_adj_mem #(
        .DEPTH  (MAX_VERTICES * MAX_VERTICES),
        .DATA_W (WB + 1)
    ) u_adj_mem (
        .clk   (clk),
        .we    (adj_we),
        .waddr (adj_waddr),
        .wdata ({item.absent, WB'(item.weight)}),
        .raddr (adj_raddr),
        .rdata (adj_rdata)
    );

    prim_mst_vtx_mem #(
        .DEPTH (MAX_VERTICES),
        .KEY_W (WB)
    ) u_vtx_mem (
        .clk     (clk),
        .we      (vtx_we),
        .waddr   (vtx_waddr),
        .wkey    (vtx_wkey),
        .wparent (vtx_wparent),
        .raddr   (idx_reg[VW-1:0]),
        .rkey    (key_rd),
        .rparent (parent_rd)
    );

    // The one comparator serves both the minimum search and the key update.
    assign adj_w    = adj_rdata[WB-1:0];
    assign cmp_a    = (state_reg == S_SEL) ? key_rd : adj_w;
    assign cmp_b    = (state_reg == S_SEL) ? best_reg : key_rd;
    assign cmp_lt   = cmp_a < cmp_b;

    assign adj_skip  = adj_rdata[WB] || (adj_w == '0) || in_tree_reg[pv_reg];
    assign sel_cand  = key_valid_reg[pv_reg] && !in_tree_reg[pv_reg];
    assign scan_done = (idx_reg == n_act) && !pend_reg;

    assign out_ew  = (in_tree_reg[pv_reg] && (pv_reg != '0)) ? key_rd : '0;
    assign out_par = (in_tree_reg[pv_reg] && (pv_reg != '0)) ? parent_rd : '0;

    always_comb
    begin
        state_next     = state_reg;
        in_tree_next   = in_tree_reg;
        key_valid_next = key_valid_reg;
        idx_next       = idx_reg;
        pend_next      = 1'b0;
        pv_next        = pv_reg;
        found_next     = found_reg;
        best_next      = best_reg;
        u_next         = u_reg;
        total_next     = total_reg;
        res_valid_next = 1'b0;
        res_next       = res_reg;
        vtx_we         = 1'b0;
        vtx_waddr      = pv_reg;
        vtx_wkey       = adj_w;
        vtx_wparent    = u_reg;

        if (state_reg != S_IDLE && idx_reg < n_act)
        begin
            idx_next  = idx_reg + CW'(1);
            pend_next = 1'b1;
            pv_next   = idx_reg[VW-1:0];
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && item.last)
                begin
                    in_tree_next   = '0;
                    key_valid_next = MAX_VERTICES'(1);
                    vtx_we         = 1'b1;
                    vtx_waddr      = '0;
                    vtx_wkey       = '0;
                    vtx_wparent    = '0;
                    idx_next       = '0;
                    found_next     = 1'b0;
                    state_next     = S_SEL;
                end
            end
            S_SEL:
            begin
                if (pend_reg && sel_cand && (!found_reg || cmp_lt))
                begin
                    found_next = 1'b1;
                    best_next  = key_rd;
                    u_next     = pv_reg;
                end
                if (scan_done)
                begin
                    idx_next = '0;
                    if (found_reg)
                    begin
                        in_tree_next[u_reg] = 1'b1;
                        state_next          = S_UPD;
                    end
                    else
                    begin
                        total_next = '0;
                        state_next = S_OUT;
                    end
                end
            end
            S_UPD:
            begin
                if (pend_reg && !adj_skip && (!key_valid_reg[pv_reg] || cmp_lt))
                begin
                    vtx_we                 = 1'b1;
                    key_valid_next[pv_reg] = 1'b1;
                end
                if (scan_done)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = S_SEL;
                end
            end
            S_OUT:
            begin
                if (pend_reg)
                begin
                    total_next            = total_reg + TW'(out_ew);
                    res_valid_next        = 1'b1;
                    res_next.vertex       = prim_mst_pkg::VIDX_W'(pv_reg);
                    res_next.parent       = prim_mst_pkg::VIDX_W'(out_par);
                    res_next.edge_weight  = prim_mst_pkg::WIN_W'(out_ew);
                    res_next.reachable    = in_tree_reg[pv_reg];
                    res_next.total_weight = total_reg + TW'(out_ew);
                    res_next.final_res    = (CW'(pv_reg) + CW'(1)) == n_act;
                end
                if (scan_done)
                begin
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vcount_reg    <= prim_mst_pkg::VCOUNT_RESET;
            in_tree_reg   <= '0;
            key_valid_reg <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_tree_reg   <= in_tree_next;
            key_valid_reg <= key_valid_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pv_reg    <= pv_next;
        best_reg  <= best_next;
        u_reg     <= u_next;
        total_reg <= total_next;
        res_reg   <= res_next;
    end

endmodule

`default_nettype wire
